// File: rtl/core/sae_pkg.sv
// Shared types, constants and lookup tables for the Small-AES exchange checker.
// Used by sae_round, sae_match, sae_accum and small_aes_exchange_check.
`default_nettype none

package sae_pkg;

	// Field widths fixed by the interface
	localparam int STATE_W     = 64;
	localparam int FIELD_W     = 48;
	localparam int TOTAL_W_DEF = 48;

	// Cells (r,r) of a packed state
	localparam logic [STATE_W-1:0] DIAG0_MASK = 64'hF000_0F00_00F0_000F;

	typedef logic [15:0] ttab_t [16];

	// Fused SubNibbles / MixColumns tables, one per input row
	localparam ttab_t TAB0 = '{
		16'hC66A, 16'h5BBE, 16'hA55F, 16'h844C, 16'h4226, 16'hFEE1, 16'hE779, 16'h7AAD,
		16'h1998, 16'h9DD4, 16'hDFF2, 16'hBCC7, 16'h6335, 16'h2113, 16'h0000, 16'h388B
	};
	localparam ttab_t TAB1 = '{
		16'hAC66, 16'hE5BB, 16'hFA55, 16'hC844, 16'h6422, 16'h1FEE, 16'h9E77, 16'hD7AA,
		16'h8199, 16'h49DD, 16'h2DFF, 16'h7BCC, 16'h5633, 16'h3211, 16'h0000, 16'hB388
	};
	localparam ttab_t TAB2 = '{
		16'h6AC6, 16'hBE5B, 16'h5FA5, 16'h4C84, 16'h2642, 16'hE1FE, 16'h79E7, 16'hAD7A,
		16'h9819, 16'hD49D, 16'hF2DF, 16'hC7BC, 16'h3563, 16'h1321, 16'h0000, 16'h8B38
	};
	localparam ttab_t TAB3 = '{
		16'h66AC, 16'hBBE5, 16'h55FA, 16'h44C8, 16'h2264, 16'hEE1F, 16'h779E, 16'hAAD7,
		16'h9981, 16'hDD49, 16'hFF2D, 16'hCC7B, 16'h3356, 16'h1132, 16'h0000, 16'h88B3
	};

	// Per-item result counts
	typedef struct packed {
		logic [3:0] mask_count;
		logic [2:0] w1_count;
		logic [2:0] w2_count;
		logic [2:0] w3_count;
		logic       any_valid;
	} counts_t;

	// Nibble at row r, column c (indices wrap mod 4)
	function automatic logic [3:0] nibble_at(input logic [STATE_W-1:0] s,
			input logic [1:0] r, input logic [1:0] c);
		logic [5:0] base;
		base = {r, c, 2'b00};
		return s[base +: 4];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sae_round.sv
// One keyed Small-AES round through the fused T-tables.
// Depends on sae_pkg for the tables and the nibble helper.
`default_nettype none

module sae_round
	import sae_pkg::*;
(
	input  wire logic [STATE_W-1:0] state_in,
	input  wire logic [STATE_W-1:0] key,
	output logic      [STATE_W-1:0] state_out
);

	logic [STATE_W-1:0] keyed;
	logic [15:0]        col [4];

	assign keyed = state_in ^ key;

	// Form each output column from one diagonal of the keyed state
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			col[j] = TAB0[nibble_at(keyed, 2'd0, 2'(j))]
				^ TAB1[nibble_at(keyed, 2'd1, 2'(j + 1))]
				^ TAB2[nibble_at(keyed, 2'd2, 2'(j + 2))]
				^ TAB3[nibble_at(keyed, 2'd3, 2'(j + 3))];
		end
	end

	// Scatter column nibbles back into row-major packing, top nibble is row 0
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 4; j++) begin
				state_out[4 * (4 * r + j) +: 4] = col[j][12 - 4 * r +: 4];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/sae_match.sv
// Diagonal keep/swap decision and valid exchange mask counting.
// Depends on sae_pkg for counts_t and the nibble helper.
`default_nettype none

module sae_match
	import sae_pkg::*;
(
	input  wire logic [STATE_W-1:0] ra,
	input  wire logic [STATE_W-1:0] rb,
	input  wire logic [STATE_W-1:0] rap,
	input  wire logic [STATE_W-1:0] rbp,
	output counts_t                 counts
);

	logic [3:0]  keep;
	logic [3:0]  swp;
	logic [14:1] ok;
	logic [3:0]  w1_bits;
	logic [5:0]  w2_bits;
	logic [3:0]  w3_bits;

	// Compare the four cells of each diagonal
	always_comb begin
		for (int d = 0; d < 4; d++) begin
			keep[d] = 1'b1;
			swp[d]  = 1'b1;
			for (int r = 0; r < 4; r++) begin
				if (nibble_at(rap, 2'(r), 2'(r + d)) != nibble_at(ra, 2'(r), 2'(r + d)) ||
						nibble_at(rbp, 2'(r), 2'(r + d)) != nibble_at(rb, 2'(r), 2'(r + d)))
					keep[d] = 1'b0;
				if (nibble_at(rap, 2'(r), 2'(r + d)) != nibble_at(rb, 2'(r), 2'(r + d)) ||
						nibble_at(rbp, 2'(r), 2'(r + d)) != nibble_at(ra, 2'(r), 2'(r + d)))
					swp[d] = 1'b0;
			end
		end
	end

	// A mask is valid when every diagonal agrees; full swap is not tested
	always_comb begin
		for (int v = 1; v <= 14; v++) begin
			ok[v] = &((4'(v) & swp) | (~4'(v) & keep));
		end
	end

	// Group masks by weight
	assign w1_bits = {ok[8], ok[4], ok[2], ok[1]};
	assign w2_bits = {ok[12], ok[10], ok[9], ok[6], ok[5], ok[3]};
	assign w3_bits = {ok[14], ok[13], ok[11], ok[7]};

	always_comb begin
		counts.w1_count   = 3'($countones(w1_bits));
		counts.w2_count   = 3'($countones(w2_bits));
		counts.w3_count   = 3'($countones(w3_bits));
		counts.mask_count = 4'(counts.w1_count) + 4'(counts.w2_count)
			+ 4'(counts.w3_count);
		counts.any_valid  = |ok;
	end

endmodule

`default_nettype wire

// File: rtl/core/sae_accum.sv
// Saturating running totals of the per-item counts.
// Depends on sae_pkg for counts_t.
`default_nettype none

module sae_accum
	import sae_pkg::*;
#(
	parameter int TOTAL_WIDTH = TOTAL_W_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   update,
	input  wire counts_t                counts,
	output logic      [TOTAL_WIDTH-1:0] success_sum,
	output logic      [TOTAL_WIDTH-1:0] mask_sum,
	output logic      [TOTAL_WIDTH-1:0] w1_sum,
	output logic      [TOTAL_WIDTH-1:0] w2_sum,
	output logic      [TOTAL_WIDTH-1:0] w3_sum
);

	localparam logic [TOTAL_WIDTH-1:0] TOP = {TOTAL_WIDTH{1'b1}};

	logic [TOTAL_WIDTH-1:0] success_q, mask_q, w1_q, w2_q, w3_q;
	logic [TOTAL_WIDTH:0]   success_nx, mask_nx, w1_nx, w2_nx, w3_nx;

	// Wide add with a carry bit for saturation
	assign success_nx = {1'b0, success_q} + (TOTAL_WIDTH + 1)'(counts.any_valid);
	assign mask_nx    = {1'b0, mask_q} + (TOTAL_WIDTH + 1)'(counts.mask_count);
	assign w1_nx      = {1'b0, w1_q} + (TOTAL_WIDTH + 1)'(counts.w1_count);
	assign w2_nx      = {1'b0, w2_q} + (TOTAL_WIDTH + 1)'(counts.w2_count);
	assign w3_nx      = {1'b0, w3_q} + (TOTAL_WIDTH + 1)'(counts.w3_count);

	// Advance totals, clamp at all ones on carry out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			success_q <= '0;
			mask_q    <= '0;
			w1_q      <= '0;
			w2_q      <= '0;
			w3_q      <= '0;
		end else if (update) begin
			success_q <= success_nx[TOTAL_WIDTH] ? TOP : success_nx[TOTAL_WIDTH-1:0];
			mask_q    <= mask_nx[TOTAL_WIDTH] ? TOP : mask_nx[TOTAL_WIDTH-1:0];
			w1_q      <= w1_nx[TOTAL_WIDTH] ? TOP : w1_nx[TOTAL_WIDTH-1:0];
			w2_q      <= w2_nx[TOTAL_WIDTH] ? TOP : w2_nx[TOTAL_WIDTH-1:0];
			w3_q      <= w3_nx[TOTAL_WIDTH] ? TOP : w3_nx[TOTAL_WIDTH-1:0];
		end
	end

	assign success_sum = success_q;
	assign mask_sum    = mask_q;
	assign w1_sum      = w1_q;
	assign w2_sum      = w2_q;
	assign w3_sum      = w3_q;

endmodule

`default_nettype wire

// File: rtl/core/small_aes_exchange_check.sv
// Small-AES diagonal exchange checker. An input item is a pair of 4x4 nibble
// states; the block swaps diagonal 0 between them, runs one keyed Small-AES round
// on all four states, and reports how many exchange masks of weight one to three
// are consistent, with saturating running totals. Throughput is one item per
// clock while out_stall does not hold the output. An item passes three registers
// (input register, count register, output/total register) in that order before
// its result is on the output.
// round_key must only be written while the block holds no item in flight.
// Depends on sae_pkg, sae_round, sae_match and sae_accum.
`default_nettype none

module small_aes_exchange_check
	import sae_pkg::*;
#(
	parameter int TOTAL_WIDTH = TOTAL_W_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_write_en,
	input  wire logic [STATE_W-1:0] round_key,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [STATE_W-1:0] first_state,
	input  wire logic [STATE_W-1:0] second_state,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [3:0]         mask_count,
	output logic      [2:0]         weight_one_count,
	output logic      [2:0]         weight_two_count,
	output logic      [2:0]         weight_three_count,
	output logic                    any_valid,
	output logic      [FIELD_W-1:0] success_total,
	output logic      [FIELD_W-1:0] masks_total,
	output logic      [FIELD_W-1:0] weight_one_total,
	output logic      [FIELD_W-1:0] weight_two_total,
	output logic      [FIELD_W-1:0] weight_three_total
);

	logic [STATE_W-1:0]     key_q;
	logic                   valid_s1, valid_s2, out_valid_q;
	logic [STATE_W-1:0]     a_s1, b_s1;
	counts_t                counts_s2, counts_q, counts_nx;
	logic [STATE_W-1:0]     ap, bp, ra, rb, rap, rbp;
	logic                   adv_out, adv_2, adv_1;
	logic [TOTAL_WIDTH-1:0] success_sum, mask_sum, w1_sum, w2_sum, w3_sum;

	// Hold the round key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_write_en) begin
			key_q <= round_key;
		end
	end

	// Stage advance: a stage moves when empty or when the next one moves
	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_2    = !valid_s2 || adv_out;
	assign adv_1    = !valid_s1 || adv_2;
	assign in_stall = !adv_1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_1 && in_valid) begin
			a_s1 <= first_state;
			b_s1 <= second_state;
		end
	end

	// Exchange diagonal 0
	assign ap = (a_s1 & ~DIAG0_MASK) | (b_s1 & DIAG0_MASK);
	assign bp = (b_s1 & ~DIAG0_MASK) | (a_s1 & DIAG0_MASK);

	sae_round u_round_a  (.state_in(a_s1), .key(key_q), .state_out(ra));
	sae_round u_round_b  (.state_in(b_s1), .key(key_q), .state_out(rb));
	sae_round u_round_ap (.state_in(ap),   .key(key_q), .state_out(rap));
	sae_round u_round_bp (.state_in(bp),   .key(key_q), .state_out(rbp));

	sae_match u_match (
		.ra     (ra),
		.rb     (rb),
		.rap    (rap),
		.rbp    (rbp),
		.counts (counts_nx)
	);

	// Count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_2 && valid_s1) begin
			counts_s2 <= counts_nx;
		end
	end

	// Output register; totals advance with the item that enters it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			counts_q <= counts_s2;
		end
	end

	sae_accum #(
		.TOTAL_WIDTH (TOTAL_WIDTH)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.update      (adv_out && valid_s2),
		.counts      (counts_s2),
		.success_sum (success_sum),
		.mask_sum    (mask_sum),
		.w1_sum      (w1_sum),
		.w2_sum      (w2_sum),
		.w3_sum      (w3_sum)
	);

	assign out_valid          = out_valid_q;
	assign mask_count         = counts_q.mask_count;
	assign weight_one_count   = counts_q.w1_count;
	assign weight_two_count   = counts_q.w2_count;
	assign weight_three_count = counts_q.w3_count;
	assign any_valid          = counts_q.any_valid;

	// Fit totals to the field width
	generate
		if (TOTAL_WIDTH >= FIELD_W) begin : g_trunc
			assign success_total      = success_sum[FIELD_W-1:0];
			assign masks_total        = mask_sum[FIELD_W-1:0];
			assign weight_one_total   = w1_sum[FIELD_W-1:0];
			assign weight_two_total   = w2_sum[FIELD_W-1:0];
			assign weight_three_total = w3_sum[FIELD_W-1:0];
		end else begin : g_ext
			assign success_total      = {{(FIELD_W - TOTAL_WIDTH){1'b0}}, success_sum};
			assign masks_total        = {{(FIELD_W - TOTAL_WIDTH){1'b0}}, mask_sum};
			assign weight_one_total   = {{(FIELD_W - TOTAL_WIDTH){1'b0}}, w1_sum};
			assign weight_two_total   = {{(FIELD_W - TOTAL_WIDTH){1'b0}}, w2_sum};
			assign weight_three_total = {{(FIELD_W - TOTAL_WIDTH){1'b0}}, w3_sum};
		end
	endgenerate

endmodule

`default_nettype wire

// File: dv/tb_small_aes_exchange_check.sv
// Testbench for small_aes_exchange_check: structured state pairs in, mask counts and
// running totals checked against a self-contained exchange-mask predictor.
// Depends on sae_pkg (port widths) and the small_aes_exchange_check RTL.
module tb_small_aes_exchange_check;
	import sae_pkg::STATE_W;
	import sae_pkg::FIELD_W;

	localparam int TOTAL_BITS = 48;
	localparam int PHASES = 5;
	localparam int PAIRS_PER_PHASE = 365;

	// Cells (r,r) of a packed state
	localparam logic [63:0] DIAG_ZERO = 64'hF000_0F00_00F0_000F;

	// Fused substitution / column-mix lookups, one per source row
	localparam logic [0:15][15:0] MIX_T0 = {
		16'hC66A, 16'h5BBE, 16'hA55F, 16'h844C, 16'h4226, 16'hFEE1, 16'hE779, 16'h7AAD,
		16'h1998, 16'h9DD4, 16'hDFF2, 16'hBCC7, 16'h6335, 16'h2113, 16'h0000, 16'h388B};
	localparam logic [0:15][15:0] MIX_T1 = {
		16'hAC66, 16'hE5BB, 16'hFA55, 16'hC844, 16'h6422, 16'h1FEE, 16'h9E77, 16'hD7AA,
		16'h8199, 16'h49DD, 16'h2DFF, 16'h7BCC, 16'h5633, 16'h3211, 16'h0000, 16'hB388};
	localparam logic [0:15][15:0] MIX_T2 = {
		16'h6AC6, 16'hBE5B, 16'h5FA5, 16'h4C84, 16'h2642, 16'hE1FE, 16'h79E7, 16'hAD7A,
		16'h9819, 16'hD49D, 16'hF2DF, 16'hC7BC, 16'h3563, 16'h1321, 16'h0000, 16'h8B38};
	localparam logic [0:15][15:0] MIX_T3 = {
		16'h66AC, 16'hBBE5, 16'h55FA, 16'h44C8, 16'h2264, 16'hEE1F, 16'h779E, 16'hAAD7,
		16'h9981, 16'hDD49, 16'hFF2D, 16'hCC7B, 16'h3356, 16'h1132, 16'h0000, 16'h88B3};

	typedef struct packed {
		logic [3:0]  mask_count;
		logic [2:0]  w1_count;
		logic [2:0]  w2_count;
		logic [2:0]  w3_count;
		logic        any_valid;
		logic [47:0] success_total;
		logic [47:0] masks_total;
		logic [47:0] w1_total;
		logic [47:0] w2_total;
		logic [47:0] w3_total;
	} mask_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write_en = 1'b0;
	logic [STATE_W-1:0] round_key = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [STATE_W-1:0] first_state = '0;
	logic [STATE_W-1:0] second_state = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [3:0]         mask_count;
	logic [2:0]         weight_one_count;
	logic [2:0]         weight_two_count;
	logic [2:0]         weight_three_count;
	logic               any_valid;
	logic [FIELD_W-1:0] success_total;
	logic [FIELD_W-1:0] masks_total;
	logic [FIELD_W-1:0] weight_one_total;
	logic [FIELD_W-1:0] weight_two_total;
	logic [FIELD_W-1:0] weight_three_total;

	int burst_left = 8;

	small_aes_exchange_check #(.TOTAL_WIDTH(TOTAL_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.round_key(round_key),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_state(first_state),
		.second_state(second_state),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mask_count(mask_count),
		.weight_one_count(weight_one_count),
		.weight_two_count(weight_two_count),
		.weight_three_count(weight_three_count),
		.any_valid(any_valid),
		.success_total(success_total),
		.masks_total(masks_total),
		.weight_one_total(weight_one_total),
		.weight_two_total(weight_two_total),
		.weight_three_total(weight_three_total)
	);

	function automatic logic [3:0] nib_at(logic [63:0] s, int r, int c);
		return s[4 * (4 * (r % 4) + (c % 4)) +: 4];
	endfunction

	// One keyed round: key mix, then one table lookup per source row per column
	function automatic logic [63:0] keyed_round(logic [63:0] st, logic [63:0] k);
		logic [63:0] s;
		logic [63:0] res;
		logic [15:0] col;
		s = st ^ k;
		res = '0;
		for (int j = 0; j < 4; j++) begin
			col = MIX_T0[nib_at(s, 0, j)] ^ MIX_T1[nib_at(s, 1, j + 1)] ^
				MIX_T2[nib_at(s, 2, j + 2)] ^ MIX_T3[nib_at(s, 3, j + 3)];
			for (int r = 0; r < 4; r++)
				res[4 * (4 * r + j) +: 4] = col[12 - 4 * r +: 4];
		end
		return res;
	endfunction

	function automatic bit diag_cells_same(logic [63:0] x, logic [63:0] y, int d);
		for (int r = 0; r < 4; r++)
			if (nib_at(x, r, r + d) != nib_at(y, r, r + d))
				return 1'b0;
		return 1'b1;
	endfunction

	// Random nonzero nibbles on about a third of the cells of the chosen source diagonals
	function automatic logic [63:0] sparse_delta(logic [3:0] diag_sel);
		logic [63:0] delta;
		delta = '0;
		for (int j = 0; j < 4; j++)
			if (diag_sel[j])
				for (int r = 0; r < 4; r++)
					if ($urandom_range(0, 2) == 0)
						delta[4 * (4 * r + (r + j) % 4) +: 4] = 4'($urandom_range(1, 15));
		return delta;
	endfunction

	// Predict mask counts per accepted pair and check results in order
	class exchange_scoreboard;
		logic [63:0]  key = '0;
		logic [63:0]  success_acc = '0;
		logic [63:0]  mask_acc = '0;
		logic [63:0]  weight_acc [3] = '{64'd0, 64'd0, 64'd0};
		mask_report_t due_counts [$];
		int unsigned  taken = 0;
		int unsigned  checked = 0;
		int unsigned  hits = 0;
		int unsigned  errors = 0;

		function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add);
			logic [63:0] top;
			top = (64'd1 << TOTAL_BITS) - 64'd1;
			if (acc > top)
				acc = top;
			if (add > top - acc)
				return top;
			return acc + add;
		endfunction

		function void note_pair(logic [63:0] a, logic [63:0] b);
			logic [63:0]  ap, bp, ra, rb, rap, rbp;
			bit           keep_d [4];
			bit           swap_d [4];
			int unsigned  wsum [3];
			int unsigned  nvalid, w;
			bit           ok, s;
			mask_report_t rep;
			ap = (a & ~DIAG_ZERO) | (b & DIAG_ZERO);
			bp = (b & ~DIAG_ZERO) | (a & DIAG_ZERO);
			ra = keyed_round(a, key);
			rb = keyed_round(b, key);
			rap = keyed_round(ap, key);
			rbp = keyed_round(bp, key);
			for (int d = 0; d < 4; d++) begin
				keep_d[d] = diag_cells_same(rap, ra, d) && diag_cells_same(rbp, rb, d);
				swap_d[d] = diag_cells_same(rap, rb, d) && diag_cells_same(rbp, ra, d);
			end
			// Masks 1..14 only: the full swap is never counted
			nvalid = 0;
			wsum = '{0, 0, 0};
			for (int v = 1; v <= 14; v++) begin
				ok = 1'b1;
				w = 0;
				for (int d = 0; d < 4; d++) begin
					s = 1'((v >> d) & 1);
					if (s)
						w++;
					if (s ? !swap_d[d] : !keep_d[d])
						ok = 1'b0;
				end
				if (ok) begin
					nvalid++;
					wsum[w - 1]++;
				end
			end
			if (nvalid > 0)
				success_acc = sat_add(success_acc, 64'd1);
			mask_acc = sat_add(mask_acc, 64'(nvalid));
			for (int d = 0; d < 3; d++)
				weight_acc[d] = sat_add(weight_acc[d], 64'(wsum[d]));
			rep.mask_count = nvalid[3:0];
			rep.w1_count = wsum[0][2:0];
			rep.w2_count = wsum[1][2:0];
			rep.w3_count = wsum[2][2:0];
			rep.any_valid = (nvalid > 0);
			rep.success_total = success_acc[47:0];
			rep.masks_total = mask_acc[47:0];
			rep.w1_total = weight_acc[0][47:0];
			rep.w2_total = weight_acc[1][47:0];
			rep.w3_total = weight_acc[2][47:0];
			due_counts.push_back(rep);
			taken++;
		endfunction

		function void match_field(string fname, logic [63:0] want, logic [63:0] seen);
			if (want !== seen) begin
				$error("%s: expected %0d, got %0d", fname, want, seen);
				errors++;
			end
		endfunction

		function void check_counts(mask_report_t got);
			mask_report_t want;
			if (due_counts.size() == 0) begin
				$error("result arrived with no item outstanding");
				errors++;
				return;
			end
			want = due_counts.pop_front();
			checked++;
			if (want.any_valid)
				hits++;
			match_field("mask_count", 64'(want.mask_count), 64'(got.mask_count));
			match_field("weight_one_count", 64'(want.w1_count), 64'(got.w1_count));
			match_field("weight_two_count", 64'(want.w2_count), 64'(got.w2_count));
			match_field("weight_three_count", 64'(want.w3_count), 64'(got.w3_count));
			match_field("any_valid", 64'(want.any_valid), 64'(got.any_valid));
			match_field("success_total", 64'(want.success_total),
				64'(got.success_total));
			match_field("masks_total", 64'(want.masks_total), 64'(got.masks_total));
			match_field("weight_one_total", 64'(want.w1_total), 64'(got.w1_total));
			match_field("weight_two_total", 64'(want.w2_total), 64'(got.w2_total));
			match_field("weight_three_total", 64'(want.w3_total), 64'(got.w3_total));
		endfunction
	endclass

	exchange_scoreboard board = new;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Watch both handshakes
	always @(posedge clk) begin : watch
		mask_report_t seen;
		if (arst_n && in_valid && !in_stall)
			board.note_pair(first_state, second_state);
		if (arst_n && out_valid && !out_stall) begin
			seen.mask_count = mask_count;
			seen.w1_count = weight_one_count;
			seen.w2_count = weight_two_count;
			seen.w3_count = weight_three_count;
			seen.any_valid = any_valid;
			seen.success_total = success_total;
			seen.masks_total = masks_total;
			seen.w1_total = weight_one_total;
			seen.w2_total = weight_two_total;
			seen.w3_total = weight_three_total;
			board.check_counts(seen);
		end
	end

	// Receiver stalls: random modes, plus one long hold-off to back up the input
	initial begin
		int          mode;
		int          span;
		int          hold_left;
		bit          held;
		int unsigned tick;
		mode = 0;
		span = 0;
		hold_left = 0;
		held = 1'b0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (!held && board.taken >= 500) begin
				held = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(20, 150);
				end
				span--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 70);
					default: out_stall <= (tick % 3 != 0);
				endcase
			end
		end
	end

	// Offer one pair, hold it until accepted, then maybe end the burst
	task automatic offer_pair(logic [63:0] a, logic [63:0] b);
		int gap;
		first_state <= a;
		second_state <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait until every expected result has been seen
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due_counts.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic load_key(logic [63:0] k);
		cfg_write_en <= 1'b1;
		round_key <= k;
		@(posedge clk);
		board.key = k;
		cfg_write_en <= 1'b0;
	endtask

	// Edge values, identical pairs, full swap, single- and two-diagonal differences and a random pair
	task automatic run_directed();
		logic [63:0] r;
		r = {$urandom, $urandom};
		offer_pair(64'h0, 64'h0);
		offer_pair('1, '1);
		offer_pair(64'h0, '1);
		offer_pair('1, 64'h0);
		offer_pair(r, r);
		offer_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		offer_pair(r, r ^ DIAG_ZERO);
		offer_pair(r, r ^ 64'h0000_0000_0000_00F0);
		offer_pair(r, r ^ 64'h0000_0000_0000_0001);
		offer_pair(r, r ^ 64'h0000_0000_0F00_00F0);
		offer_pair(r, r ^ 64'h0000_0A00_0000_3000 ^ 64'h0000_0000_0050_0000);
		offer_pair(r, {$urandom, $urandom});
	endtask

	// Main sequence
	initial begin
		logic [63:0] phase_keys [PHASES];
		logic [63:0] a, b;
		logic [2:0]  sel_hi;
		int          kind;
		phase_keys[0] = 64'h0;
		phase_keys[1] = '1;
		phase_keys[2] = {$urandom, $urandom};
		phase_keys[3] = {$urandom, $urandom};
		phase_keys[4] = {$urandom, $urandom};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			load_key(phase_keys[p]);
			if (p < 2)
				run_directed();
			for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
				a = {$urandom, $urandom};
				kind = $urandom_range(0, 9);
				sel_hi = 3'($urandom_range(1, 7));
				// Mostly pairs that differ on a few diagonals, so masks actually hit
				case (kind)
					0, 1: b = {$urandom, $urandom};
					2: b = a;
					3, 4: b = a ^ sparse_delta({sel_hi, 1'b0});
					5, 6: b = a ^ sparse_delta(4'b0001);
					default: b = a ^ sparse_delta({sel_hi, 1'b1});
				endcase
				offer_pair(a, b);
			end
			settle();
		end
		repeat (10) @(posedge clk);
		$display("Ran %0d state pairs under %0d round keys, including a long output hold-off.",
			board.taken, PHASES);
		$display("Checked %0d results; %0d had at least one consistent exchange mask.",
			board.checked, board.hits);
		if (board.errors == 0 && board.due_counts.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Overall time limit
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
